@@ hw/rtl/ddo_pkg.sv @@
// Shared types, constants and tables for the differential-drive odometry block.
// Used by ddo_serial_alu and diff_drive_odometry_and_kinematics; depends on nothing.
`default_nettype none

package ddo_pkg;

    // Item payloads.
    typedef struct packed {
        logic               action;
        logic signed [31:0] forward_velocity_cmd;
        logic signed [31:0] turn_rate_cmd;
        logic        [19:0] step_time;
        logic signed [31:0] left_wheel_rate_meas;
        logic signed [31:0] right_wheel_rate_meas;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] left_drive_rate;
        logic signed [31:0] right_drive_rate;
        logic signed [47:0] pose_x;
        logic signed [47:0] pose_y;
        logic        [31:0] heading;
        logic signed [31:0] odom_linear_velocity;
        logic signed [31:0] odom_angular_velocity;
        logic               zero_step_flag;
    } t_out_item;

    // Item kinds.
    localparam logic ACTION_CMD  = 1'b0;
    localparam logic ACTION_TICK = 1'b1;

    // Configuration register indexes and reset values.
    localparam int          CFG_IDX_W           = 2;
    localparam int          CFG_DATA_W          = 32;
    localparam logic [1:0]  REG_WHEEL_RADIUS    = 2'd0;
    localparam logic [1:0]  REG_WHEEL_SEPARATION = 2'd1;
    localparam logic [1:0]  REG_TIMEOUT_TICKS   = 2'd2;
    localparam logic [30:0] RADIUS_RESET        = 31'd4915;
    localparam logic [30:0] SEPARATION_RESET    = 31'd22282;
    localparam logic [15:0] TIMEOUT_RESET       = 16'd100;

    // Arithmetic constants.
    localparam int           CORDIC_STEPS_DEF = 16;
    localparam logic [29:0]  TURN_K           = 30'd683565276;
    localparam logic [33:0]  CORDIC_X0        = 34'd652032875;
    localparam logic [31:0]  QUARTER_HALF     = 32'h2000_0000;

    // Serial unit.
    localparam int         CNT_W        = 7;
    localparam logic [6:0] MUL_CYCLES   = 7'd64;
    localparam logic [6:0] DIV64_CYCLES = 7'd64;
    localparam logic [6:0] DIV80_CYCLES = 7'd80;

    typedef enum logic {
        ALU_MUL,
        ALU_DIV
    } t_alu_mode;

    typedef struct packed {
        logic              start;
        t_alu_mode         mode;
        logic [CNT_W-1:0]  count;
    } t_alu_req;

    // Sequencer states and arithmetic steps of one tick.
    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_CORDIC,
        S_FINISH
    } t_state;

    typedef enum logic [3:0] {
        OP_WS,
        OP_DIVL,
        OP_DIVR,
        OP_P,
        OP_DR,
        OP_DD,
        OP_DA,
        OP_HB,
        OP_PX,
        OP_PY,
        OP_LIN,
        OP_ANGM,
        OP_ANGD
    } t_op;

    // Truncated arctangent of 2^-i in binary-angle units.
    function automatic logic [31:0] atan_entry(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h2000_0000;
            5'd1:    v = 32'h12E4_051E;
            5'd2:    v = 32'h09FB_385B;
            5'd3:    v = 32'h0511_11D4;
            5'd4:    v = 32'h028B_0D43;
            5'd5:    v = 32'h0145_D7E1;
            5'd6:    v = 32'h00A2_F61E;
            5'd7:    v = 32'h0051_7C55;
            5'd8:    v = 32'h0028_BE53;
            5'd9:    v = 32'h0014_5F2F;
            5'd10:   v = 32'h000A_2F98;
            5'd11:   v = 32'h0005_17CC;
            5'd12:   v = 32'h0002_8BE6;
            5'd13:   v = 32'h0001_45F3;
            5'd14:   v = 32'h0000_A2F9;
            5'd15:   v = 32'h0000_517C;
            5'd16:   v = 32'h0000_28BE;
            5'd17:   v = 32'h0000_145F;
            5'd18:   v = 32'h0000_0A2F;
            5'd19:   v = 32'h0000_0517;
            5'd20:   v = 32'h0000_028B;
            5'd21:   v = 32'h0000_0145;
            5'd22:   v = 32'h0000_00A2;
            5'd23:   v = 32'h0000_0051;
            5'd24:   v = 32'h0000_0028;
            5'd25:   v = 32'h0000_0014;
            5'd26:   v = 32'h0000_000A;
            5'd27:   v = 32'h0000_0005;
            5'd28:   v = 32'h0000_0002;
            5'd29:   v = 32'h0000_0001;
            default: v = 32'h0000_0000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ddo_serial_alu.sv @@
// Bit-serial unsigned multiplier and restoring divider, one bit per cycle.
// Depends on ddo_pkg for the request struct and mode codes.
`default_nettype none

module ddo_serial_alu (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire ddo_pkg::t_alu_req   i_req,
    input  wire logic [63:0]         i_op_a,
    input  wire logic [79:0]         i_op_b,
    output logic                     o_done,
    output logic [127:0]             o_product,
    output logic [63:0]              o_quotient
);
    import ddo_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    t_alu_mode        r_mode;
    logic [63:0]      r_a;
    logic [63:0]      r_acc;
    logic [79:0]      r_sh;

    logic [64:0]      mul_sum;
    logic [32:0]      div_t;
    logic [32:0]      div_diff;
    logic             div_ge;
    logic [63:0]      n_acc;
    logic [79:0]      n_sh;

    // Multiply: add the multiplicand when the low bit is set, then shift the
    // pair right. Divide: shift one dividend bit into the remainder and subtract the divisor when it fits.
    always_comb begin
        mul_sum  = {1'b0, r_acc} + (r_sh[0] ? {1'b0, r_a} : 65'd0);
        div_t    = {r_acc[31:0], r_sh[79]};
        div_ge   = div_t >= {1'b0, r_a[31:0]};
        div_diff = div_t - {1'b0, r_a[31:0]};
        case (r_mode)
            ALU_MUL: begin
                n_acc = mul_sum[64:1];
                n_sh  = {r_sh[79:64], mul_sum[0], r_sh[63:1]};
            end
            ALU_DIV: begin
                n_acc = {32'd0, div_ge ? div_diff[31:0] : div_t[31:0]};
                n_sh  = {r_sh[78:0], div_ge};
            end
            default: begin
                n_acc = r_acc;
                n_sh  = r_sh;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.count;
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_mode <= i_req.mode;
            r_a    <= i_op_a;
            r_acc  <= '0;
            r_sh   <= i_op_b;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_sh  <= n_sh;
        end
    end

    assign o_done     = r_done;
    assign o_product  = {r_acc, r_sh[63:0]};
    assign o_quotient = r_sh[63:0];

endmodule

`default_nettype wire

@@ hw/rtl/diff_drive_odometry_and_kinematics.sv @@
// Differential-drive wheel-rate generator and dead-reckoning odometer, top level.
// Depends on ddo_pkg and instantiates ddo_serial_alu.
`default_nettype none

// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_ready   i_in_data   (t_in_item)
// result    out        o_out_valid / i_out_ready o_out_data  (t_out_item)
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A command item is taken while the sequencer is idle and gives no result. A tick
// item runs from its transfer to its result being valid through twelve 64-step
// and one 80-step operation in the shared bit-serial multiply and divide unit,
// plus one CORDIC rotation per cycle. Reset is synchronous and active
// low; it loads the register defaults and clears the command, counter and pose.
// A result waiting in the output register does not block the next input transfer;
// only the final write of a tick waits for that register to drain.

module diff_drive_odometry_and_kinematics #(
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire ddo_pkg::t_in_item                 i_in_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output ddo_pkg::t_out_item                     o_out_data,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [ddo_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [ddo_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import ddo_pkg::*;

    localparam int ITER_W = $clog2(CORDIC_STEPS + 1);

    // Sequencer.
    t_state r_state, n_state;
    t_op    r_op;

    // Configuration registers.
    logic [30:0] r_wheel_radius;
    logic [30:0] r_wheel_separation;
    logic [15:0] r_timeout_ticks;

    // Architectural state.
    logic [31:0] r_fwd_hold;
    logic [31:0] r_turn_hold;
    logic [15:0] r_ticks;
    logic [47:0] r_pos_x;
    logic [47:0] r_pos_y;
    logic [31:0] r_heading;

    // Output register.
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item out_next;
    logic      out_free;

    // Working registers of one tick.
    t_in_item    r_in;
    logic [63:0] r_ws;
    logic [31:0] r_left;
    logic [31:0] r_right;
    logic [50:0] r_p;
    logic [63:0] r_dr;
    logic [63:0] r_dd;
    logic [63:0] r_da;
    logic [31:0] r_dbam;
    logic [31:0] r_lin;
    logic [63:0] r_angm;
    logic [31:0] r_ang;

    // CORDIC rotator.
    logic signed [33:0] r_cx, r_cy;
    logic signed [32:0] r_cz;
    logic [1:0]         r_quad;
    logic [ITER_W-1:0]  r_citer;
    logic [33:0]        r_cos, r_sin;
    logic               cordic_last;
    logic signed [33:0] x_sh, y_sh, n_cx, n_cy;
    logic signed [32:0] atan_v, n_cz;
    logic [31:0]        ang_off;
    logic [32:0]        z0;

    // Serial unit interface.
    t_alu_req     alu_req;
    logic [63:0]  alu_a;
    logic [79:0]  alu_b;
    logic         alu_done;
    logic [127:0] alu_prod;
    logic [63:0]  alu_quo;

    // Derived operands.
    logic [30:0] radius_eff, sep_eff;
    logic [31:0] w_mag;
    logic [63:0] v_scaled, num_l, num_r;
    logic [31:0] wl, wr;
    logic [32:0] s_sum, s_dif, s_mag, dif_mag;
    logic [63:0] dr_mag, dd_mag;
    logic [33:0] cos_mag, sin_mag;
    logic        dt_zero;
    logic [84:0] sp85_s, sp85_d;
    logic [95:0] sp96_x, sp96_y;
    logic [64:0] sp65;
    logic [15:0] ticks_inc;

    function automatic logic [63:0] mag64(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    // Signed result from a magnitude quotient, saturated to 32 bits.
    function automatic logic [31:0] sat_quo(input logic [63:0] q, input logic neg);
        logic [31:0] v;
        if (!neg) begin
            v = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
        end else begin
            v = (q > 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - q[31:0]);
        end
        return v;
    endfunction

    function automatic logic [31:0] sat48(input logic [47:0] v);
        logic [31:0] r;
        if (!v[47] && (v[46:31] != 16'h0000)) begin
            r = 32'h7FFF_FFFF;
        end else if (v[47] && (v[46:31] != 16'hFFFF)) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // A zero radius or separation acts as one.
    assign radius_eff = (r_wheel_radius == 31'd0) ? 31'd1 : r_wheel_radius;
    assign sep_eff    = (r_wheel_separation == 31'd0) ? 31'd1 : r_wheel_separation;

    // Drive-rate numerators: v*2^17 -/+ w*sep, all in 64-bit two's complement.
    assign w_mag    = r_turn_hold[31] ? (32'd0 - r_turn_hold) : r_turn_hold;
    assign v_scaled = {{15{r_fwd_hold[31]}}, r_fwd_hold, 17'd0};
    assign num_l    = v_scaled - r_ws;
    assign num_r    = v_scaled + r_ws;

    // Wheel sum and difference of the measured rates.
    assign wl      = r_in.left_wheel_rate_meas;
    assign wr      = r_in.right_wheel_rate_meas;
    assign s_sum   = {wl[31], wl} + {wr[31], wr};
    assign s_dif   = {wl[31], wl} - {wr[31], wr};
    assign s_mag   = s_sum[32] ? (33'd0 - s_sum) : s_sum;
    assign dif_mag = s_dif[32] ? (33'd0 - s_dif) : s_dif;
    assign dt_zero = (r_in.step_time == 20'd0);

    assign dr_mag  = mag64(r_dr);
    assign dd_mag  = mag64(r_dd);
    assign cos_mag = r_cos[33] ? (34'd0 - r_cos) : r_cos;
    assign sin_mag = r_sin[33] ? (34'd0 - r_sin) : r_sin;

    // Signed products rebuilt from the unit's magnitude products. Taking the
    // upper bits of the two's complement value gives a floor toward minus infinity.
    assign sp85_s = s_sum[32] ? (85'd0 - alu_prod[84:0]) : alu_prod[84:0];
    assign sp85_d = s_dif[32] ? (85'd0 - alu_prod[84:0]) : alu_prod[84:0];
    assign sp96_x = (r_dr[63] ^ r_cos[33]) ? (96'd0 - alu_prod[95:0]) : alu_prod[95:0];
    assign sp96_y = (r_dr[63] ^ r_sin[33]) ? (96'd0 - alu_prod[95:0]) : alu_prod[95:0];
    assign sp65   = s_sum[32] ? (65'd0 - alu_prod[64:0]) : alu_prod[64:0];

    // The timeout counter saturates and the command is dropped on the tick
    // where it equals the timeout.
    assign ticks_inc = (r_ticks != 16'hFFFF) ? (r_ticks + 16'd1) : r_ticks;

    // One CORDIC rotation per cycle; right shifts are arithmetic.
    always_comb begin
        x_sh        = r_cx >>> r_citer;
        y_sh        = r_cy >>> r_citer;
        atan_v      = $signed({1'b0, atan_entry(5'(r_citer))});
        cordic_last = (r_citer == ITER_W'(CORDIC_STEPS));
        if (!r_cz[32]) begin
            n_cx = r_cx - y_sh;
            n_cy = r_cy + x_sh;
            n_cz = r_cz - atan_v;
        end else begin
            n_cx = r_cx + y_sh;
            n_cy = r_cy - x_sh;
            n_cz = r_cz + atan_v;
        end
        // Reduce the heading to the nearest quarter turn and a residual.
        ang_off = r_heading + QUARTER_HALF;
        z0      = {3'b000, ang_off[29:0]} - {1'b0, QUARTER_HALF};
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        out_next.left_drive_rate       = r_left;
        out_next.right_drive_rate      = r_right;
        out_next.pose_x                = r_pos_x;
        out_next.pose_y                = r_pos_y;
        out_next.heading               = r_heading + r_dbam;
        out_next.odom_linear_velocity  = dt_zero ? 32'd0 : r_lin;
        out_next.odom_angular_velocity = dt_zero ? 32'd0 : r_ang;
        out_next.zero_step_flag        = dt_zero;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && (i_in_data.action == ACTION_TICK)) begin
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (alu_done) begin
                    if (r_op == OP_HB) begin
                        n_state = S_CORDIC;
                    end else if (r_op == OP_ANGD) begin
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_ISSUE;
                    end
                end
            end
            S_CORDIC: begin
                if (cordic_last) begin
                    n_state = S_ISSUE;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer: input ready and the request to the serial unit.
    always_comb begin
        o_in_ready    = (r_state == S_IDLE);
        alu_req.start = (r_state == S_ISSUE);
        alu_req.mode  = ALU_MUL;
        alu_req.count = MUL_CYCLES;
        alu_a         = 64'd0;
        alu_b         = 80'd0;
        case (r_op)
            OP_WS: begin
                alu_a = 64'(w_mag);
                alu_b = 80'(sep_eff);
            end
            OP_DIVL: begin
                alu_req.mode  = ALU_DIV;
                alu_req.count = DIV64_CYCLES;
                alu_a         = 64'({radius_eff, 1'b0});
                alu_b         = {mag64(num_l), 16'd0};
            end
            OP_DIVR: begin
                alu_req.mode  = ALU_DIV;
                alu_req.count = DIV64_CYCLES;
                alu_a         = 64'({radius_eff, 1'b0});
                alu_b         = {mag64(num_r), 16'd0};
            end
            OP_P: begin
                alu_a = 64'(radius_eff);
                alu_b = 80'(r_in.step_time);
            end
            OP_DR: begin
                alu_a = 64'(r_p);
                alu_b = 80'(s_mag);
            end
            OP_DD: begin
                alu_a = 64'(r_p);
                alu_b = 80'(dif_mag);
            end
            OP_DA: begin
                // The turn is the travel difference times 2^16 over the separation.
                alu_req.mode  = ALU_DIV;
                alu_req.count = DIV80_CYCLES;
                alu_a         = 64'(sep_eff);
                alu_b         = {dd_mag, 16'd0};
            end
            OP_HB: begin
                alu_a = r_da;
                alu_b = 80'(TURN_K);
            end
            OP_PX: begin
                alu_a = dr_mag;
                alu_b = 80'(cos_mag);
            end
            OP_PY: begin
                alu_a = dr_mag;
                alu_b = 80'(sin_mag);
            end
            OP_LIN: begin
                alu_a = 64'(radius_eff);
                alu_b = 80'(s_mag);
            end
            OP_ANGM: begin
                alu_a = 64'(radius_eff);
                alu_b = 80'(dif_mag);
            end
            OP_ANGD: begin
                alu_req.mode  = ALU_DIV;
                alu_req.count = DIV64_CYCLES;
                alu_a         = 64'(sep_eff);
                alu_b         = {r_angm, 16'd0};
            end
            default: begin
                alu_a = 64'd0;
            end
        endcase
    end

    ddo_serial_alu u_alu (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (alu_req),
        .i_op_a     (alu_a),
        .i_op_b     (alu_b),
        .o_done     (alu_done),
        .o_product  (alu_prod),
        .o_quotient (alu_quo)
    );

    // Control and architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state            <= S_IDLE;
            r_op               <= OP_WS;
            r_out_valid        <= 1'b0;
            r_wheel_radius     <= RADIUS_RESET;
            r_wheel_separation <= SEPARATION_RESET;
            r_timeout_ticks    <= TIMEOUT_RESET;
            r_fwd_hold         <= 32'd0;
            r_turn_hold        <= 32'd0;
            r_ticks            <= 16'd0;
            r_pos_x            <= 48'd0;
            r_pos_y            <= 48'd0;
            r_heading          <= 32'd0;
            r_citer            <= '0;
        end else begin
            r_state <= n_state;

            // Configuration writes; an unknown index is ignored.
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_WHEEL_RADIUS:     r_wheel_radius     <= i_cfg_data[30:0];
                    REG_WHEEL_SEPARATION: r_wheel_separation <= i_cfg_data[30:0];
                    REG_TIMEOUT_TICKS:    r_timeout_ticks    <= i_cfg_data[15:0];
                    default:              ;
                endcase
            end

            // The output register fills when a tick ends and empties on a result
            // transfer; both can happen at the same edge.
            if ((r_state == S_FINISH) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        if (i_in_data.action == ACTION_CMD) begin
                            r_fwd_hold  <= i_in_data.forward_velocity_cmd;
                            r_turn_hold <= i_in_data.turn_rate_cmd;
                            r_ticks     <= 16'd0;
                        end else begin
                            r_op <= OP_WS;
                        end
                    end
                end
                S_WAIT: begin
                    if (alu_done) begin
                        if (r_op != OP_ANGD) begin
                            r_op <= t_op'(r_op + 4'd1);
                        end
                        if (r_op == OP_HB) begin
                            r_citer <= '0;
                        end
                        if (r_op == OP_PX) begin
                            r_pos_x <= r_pos_x + sp96_x[93:46];
                        end
                        if (r_op == OP_PY) begin
                            r_pos_y <= r_pos_y + sp96_y[93:46];
                        end
                    end
                end
                S_CORDIC: begin
                    if (!cordic_last) begin
                        r_citer <= r_citer + ITER_W'(1);
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_heading   <= r_heading + r_dbam;
                        r_ticks     <= ticks_inc;
                        if (ticks_inc == r_timeout_ticks) begin
                            r_fwd_hold  <= 32'd0;
                            r_turn_hold <= 32'd0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers of one tick.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_in <= i_in_data;
                end
            end
            S_WAIT: begin
                if (alu_done) begin
                    case (r_op)
                        OP_WS:   r_ws    <= r_turn_hold[31] ? (64'd0 - alu_prod[63:0])
                                                            : alu_prod[63:0];
                        OP_DIVL: r_left  <= sat_quo(alu_quo, num_l[63]);
                        OP_DIVR: r_right <= sat_quo(alu_quo, num_r[63]);
                        OP_P:    r_p     <= alu_prod[50:0];
                        OP_DR:   r_dr    <= sp85_s[84:21];
                        OP_DD:   r_dd    <= sp85_d[83:20];
                        OP_DA:   r_da    <= r_dd[63] ? (64'd0 - alu_quo) : alu_quo;
                        OP_HB: begin
                            r_dbam <= alu_prod[63:32];
                            r_cx   <= $signed(CORDIC_X0);
                            r_cy   <= 34'sd0;
                            r_cz   <= $signed(z0);
                            r_quad <= ang_off[31:30];
                        end
                        OP_LIN:  r_lin   <= sat48(sp65[64:17]);
                        OP_ANGM: r_angm  <= alu_prod[63:0];
                        OP_ANGD: r_ang   <= sat_quo(alu_quo, s_dif[32]);
                        default: ;
                    endcase
                end
            end
            S_CORDIC: begin
                if (!cordic_last) begin
                    r_cx <= n_cx;
                    r_cy <= n_cy;
                    r_cz <= n_cz;
                end else begin
                    // Rotate the result back by the quarter turn removed earlier.
                    case (r_quad)
                        2'd0: begin
                            r_cos <= r_cx;
                            r_sin <= r_cy;
                        end
                        2'd1: begin
                            r_cos <= 34'd0 - r_cy;
                            r_sin <= r_cx;
                        end
                        2'd2: begin
                            r_cos <= 34'd0 - r_cx;
                            r_sin <= 34'd0 - r_cy;
                        end
                        default: begin
                            r_cos <= r_cy;
                            r_sin <= 34'd0 - r_cx;
                        end
                    endcase
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    r_out <= out_next;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire
